// ===== src/ipdc_pkg.sv =====
// Package for the +IPD text command colour parser.
// Holds character codes, parse phase codes, outcome codes, word tables and the result type.
// No dependencies.
package ipdc_pkg;

  localparam int LINE_MAX_DEF = 128;
  localparam int KEY_MAX_DEF  = 16;

  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_EQ    = 8'h3d;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_NUL   = 8'h00;

  localparam logic [2:0] PH_PREFIX = 3'd0;
  localparam logic [2:0] PH_COLON  = 3'd1;
  localparam logic [2:0] PH_KEY    = 3'd2;
  localparam logic [2:0] PH_VALUE  = 3'd3;
  localparam logic [2:0] PH_NOTIPD = 3'd4;
  localparam logic [2:0] PH_DEAD   = 3'd5;

  localparam logic [1:0] OUT_NOT_IPD = 2'd0;
  localparam logic [1:0] OUT_NO_CMD  = 2'd1;
  localparam logic [1:0] OUT_HANDLED = 2'd2;

  localparam int WORD_SLOTS = 12;

  localparam logic [95:0] KEY_RED   = {"red", 72'd0};
  localparam logic [95:0] KEY_GREEN = {"green", 56'd0};
  localparam logic [95:0] KEY_BLUE  = {"blue", 64'd0};
  localparam logic [95:0] KEY_MODE  = {"colormode", 24'd0};
  localparam logic [95:0] WORD_ON   = {"on", 80'd0};
  localparam logic [95:0] WORD_OFF  = {"off", 72'd0};
  localparam logic [95:0] WORD_SING = {"singlecolor", 8'd0};
  localparam logic [95:0] WORD_GRAD = {"gardient", 32'd0};

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       mode;
    logic [1:0] outcome;
  } ipdc_result_t;

  function automatic logic [7:0] slot_char(logic [95:0] s, logic [7:0] idx);
    logic [3:0] sh;
    if (idx >= 8'(WORD_SLOTS)) begin
      return CH_NUL;
    end
    sh = 4'(4'd11 - idx[3:0]);
    return 8'(s >> {sh, 3'b000});
  endfunction

  function automatic logic [7:0] key_char(logic [1:0] w, logic [7:0] idx);
    logic [95:0] s;
    case (w)
      2'd0: s = KEY_RED;
      2'd1: s = KEY_GREEN;
      2'd2: s = KEY_BLUE;
      default: s = KEY_MODE;
    endcase
    return slot_char(s, idx);
  endfunction

  function automatic logic [7:0] word_char(logic [1:0] w, logic [7:0] idx);
    logic [95:0] s;
    case (w)
      2'd0: s = WORD_ON;
      2'd1: s = WORD_OFF;
      2'd2: s = WORD_SING;
      default: s = WORD_GRAD;
    endcase
    return slot_char(s, idx);
  endfunction

  function automatic logic [3:0] key_len(logic [1:0] w);
    case (w)
      2'd0: return 4'd3;
      2'd1: return 4'd5;
      2'd2: return 4'd4;
      default: return 4'd9;
    endcase
  endfunction

  function automatic logic [3:0] word_len(logic [1:0] w);
    case (w)
      2'd0: return 4'd2;
      2'd1: return 4'd3;
      2'd2: return 4'd11;
      default: return 4'd8;
    endcase
  endfunction

  function automatic logic [7:0] prefix_char(logic [1:0] p);
    case (p)
      2'd0: return "+";
      2'd1: return "I";
      2'd2: return "P";
      default: return "D";
    endcase
  endfunction

endpackage

// ===== src/ipdc_parser.sv =====
// Running line parser: keeps line, key and value state and the colour registers.
// Depends on ipdc_pkg for codes, word tables and the result type.
module ipdc_parser #(
  parameter int LINE_MAX = ipdc_pkg::LINE_MAX_DEF,
  parameter int KEY_MAX  = ipdc_pkg::KEY_MAX_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    take,
  input  logic [7:0]              rx_byte,
  output logic                    emit,
  output ipdc_pkg::ipdc_result_t  result
);
  import ipdc_pkg::*;

  localparam int LL_W = $clog2(LINE_MAX);
  localparam int KL_W = $clog2(KEY_MAX + 1);

  logic [LL_W-1:0] line_length, line_length_next;
  logic [2:0]      parse_phase, parse_phase_next;
  logic [KL_W-1:0] key_length, key_length_next;
  logic [3:0]      key_candidates, key_candidates_next;
  logic [3:0]      word_candidates, word_candidates_next;
  logic [7:0]      value_acc, value_acc_next;
  logic            value_negative, value_negative_next;
  logic            value_numeric, value_numeric_next;
  logic [3:0]      value_length, value_length_next;
  logic            key_nul, key_nul_next;
  logic            value_nul, value_nul_next;
  logic            digits_open, digits_open_next;
  logic [7:0]      red_reg, red_reg_next;
  logic [7:0]      green_reg, green_reg_next;
  logic [7:0]      blue_reg, blue_reg_next;
  logic            mode_reg, mode_reg_next;

  logic            end_byte;
  logic            digit;
  logic [KL_W-1:0] kl_inc;
  logic [3:0]      sel;
  logic [3:0]      words;
  logic [7:0]      level;
  logic [1:0]      outcome;

  always_comb begin
    line_length_next     = line_length;
    parse_phase_next     = parse_phase;
    key_length_next      = key_length;
    key_candidates_next  = key_candidates;
    word_candidates_next = word_candidates;
    value_acc_next       = value_acc;
    value_negative_next  = value_negative;
    value_numeric_next   = value_numeric;
    value_length_next    = value_length;
    key_nul_next         = key_nul;
    value_nul_next       = value_nul;
    digits_open_next     = digits_open;
    red_reg_next         = red_reg;
    green_reg_next       = green_reg;
    blue_reg_next        = blue_reg;
    mode_reg_next        = mode_reg;
    outcome              = OUT_NOT_IPD;
    level                = 8'd0;

    end_byte = (rx_byte == CH_CR) || (rx_byte == CH_LF) ||
               (line_length == LL_W'(LINE_MAX - 1));
    emit     = end_byte && (line_length != '0);
    digit    = rx_byte inside {[CH_ZERO:CH_NINE]};
    kl_inc   = key_length + 1'b1;

    sel = 4'd0;
    for (int w = 0; w < 4; w++) begin
      sel[w] = key_candidates[w] &&
               (key_nul || (KL_W'(key_len(2'(w))) == key_length));
    end
    words = 4'd0;
    for (int w = 0; w < 4; w++) begin
      words[w] = word_candidates[w] && (value_nul || (word_len(2'(w)) == value_length));
    end

    if (!end_byte) begin
      line_length_next = line_length + 1'b1;
      case (parse_phase)
        PH_PREFIX: begin
          if ((line_length > LL_W'(3)) || (rx_byte != prefix_char(line_length[1:0]))) begin
            parse_phase_next = PH_NOTIPD;
          end else if (line_length == LL_W'(3)) begin
            parse_phase_next = PH_COLON;
          end
        end
        PH_COLON: begin
          if (rx_byte == CH_COLON) begin
            parse_phase_next    = PH_KEY;
            key_length_next     = '0;
            key_candidates_next = 4'hf;
            key_nul_next        = 1'b0;
          end
        end
        PH_KEY: begin
          if (rx_byte == CH_EQ) begin
            if (sel == 4'd0) begin
              parse_phase_next = PH_DEAD;
            end else begin
              key_candidates_next  = sel;
              word_candidates_next = 4'hf;
              parse_phase_next     = PH_VALUE;
            end
          end else begin
            if (!key_nul) begin
              for (int w = 0; w < 4; w++) begin
                if (key_char(2'(w), 8'(key_length)) != rx_byte) begin
                  key_candidates_next[w] = 1'b0;
                end
              end
              if (rx_byte == CH_NUL) begin
                key_nul_next = 1'b1;
              end
            end
            key_length_next = kl_inc;
            if (kl_inc >= KL_W'(KEY_MAX)) begin
              parse_phase_next = PH_DEAD;
            end
          end
        end
        PH_VALUE: begin
          if ((value_length == 4'd0) && (digit || (rx_byte == CH_MINUS))) begin
            value_numeric_next = 1'b1;
            digits_open_next   = 1'b1;
            if (digit) begin
              value_acc_next = {4'd0, rx_byte[3:0]};
            end else begin
              value_negative_next = 1'b1;
            end
          end else if (value_numeric && digits_open) begin
            if (digit) begin
              value_acc_next = {value_acc[4:0], 3'b000} + {value_acc[6:0], 1'b0} +
                               {4'd0, rx_byte[3:0]};
            end else begin
              digits_open_next = 1'b0;
            end
          end
          if (!value_nul) begin
            for (int w = 0; w < 4; w++) begin
              if (word_char(2'(w), 8'(value_length)) != rx_byte) begin
                word_candidates_next[w] = 1'b0;
              end
            end
            if (rx_byte == CH_NUL) begin
              value_nul_next = 1'b1;
            end
          end
          if (value_length != 4'd15) begin
            value_length_next = value_length + 1'b1;
          end
        end
        default: begin
        end
      endcase
    end else if (emit) begin
      case (parse_phase)
        PH_PREFIX, PH_NOTIPD: outcome = OUT_NOT_IPD;
        PH_VALUE: begin
          if (key_candidates[2:0] != 3'd0) begin
            if (key_candidates[0]) begin
              level = red_reg;
            end else if (key_candidates[1]) begin
              level = green_reg;
            end else begin
              level = blue_reg;
            end
            if (value_numeric) begin
              level = value_negative ? 8'(8'd0 - value_acc) : value_acc;
            end
            if (words[0]) begin
              level = 8'd255;
            end
            if (words[1]) begin
              level = 8'd0;
            end
            if (key_candidates[0]) begin
              red_reg_next = level;
            end else if (key_candidates[1]) begin
              green_reg_next = level;
            end else begin
              blue_reg_next = level;
            end
            outcome = OUT_HANDLED;
          end else if (key_candidates[3]) begin
            if (words[2]) begin
              mode_reg_next = 1'b0;
            end
            if (words[3]) begin
              mode_reg_next = 1'b1;
            end
            outcome = OUT_HANDLED;
          end else begin
            outcome = OUT_NO_CMD;
          end
        end
        default: outcome = OUT_NO_CMD;
      endcase
      line_length_next     = '0;
      parse_phase_next     = PH_PREFIX;
      key_length_next      = '0;
      key_candidates_next  = 4'hf;
      word_candidates_next = 4'hf;
      value_acc_next       = 8'd0;
      value_negative_next  = 1'b0;
      value_numeric_next   = 1'b0;
      value_length_next    = 4'd0;
      key_nul_next         = 1'b0;
      value_nul_next       = 1'b0;
      digits_open_next     = 1'b0;
    end

    result.red     = red_reg_next;
    result.green   = green_reg_next;
    result.blue    = blue_reg_next;
    result.mode    = mode_reg_next;
    result.outcome = outcome;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_length     <= '0;
      parse_phase     <= PH_PREFIX;
      key_length      <= '0;
      key_candidates  <= 4'hf;
      word_candidates <= 4'hf;
      value_acc       <= 8'd0;
      value_negative  <= 1'b0;
      value_numeric   <= 1'b0;
      value_length    <= 4'd0;
      key_nul         <= 1'b0;
      value_nul       <= 1'b0;
      digits_open     <= 1'b0;
      red_reg         <= 8'd0;
      green_reg       <= 8'd0;
      blue_reg        <= 8'd0;
      mode_reg        <= 1'b0;
    end else if (take) begin
      line_length     <= line_length_next;
      parse_phase     <= parse_phase_next;
      key_length      <= key_length_next;
      key_candidates  <= key_candidates_next;
      word_candidates <= word_candidates_next;
      value_acc       <= value_acc_next;
      value_negative  <= value_negative_next;
      value_numeric   <= value_numeric_next;
      value_length    <= value_length_next;
      key_nul         <= key_nul_next;
      value_nul       <= value_nul_next;
      digits_open     <= digits_open_next;
      red_reg         <= red_reg_next;
      green_reg       <= green_reg_next;
      blue_reg        <= blue_reg_next;
      mode_reg        <= mode_reg_next;
    end
  end

endmodule

// ===== src/ipd_text_command_color_parser.sv =====
// Top level of the +IPD text command colour parser: input register, parser, result register.
// Depends on ipdc_pkg and ipdc_parser.
//
// The block takes one received byte per clock cycle while it does not stall, and gives one
// result item for each nonempty line: the byte is held in the input register, the parser
// decides it in a single pass, and the result item is registered in the result register
// when the parser takes the byte ending the line, then waits there until it is taken.
// Bytes inside a line keep flowing while a result waits to be taken; only a byte that ends
// a nonempty line waits in the input register until the result register is free.
module ipd_text_command_color_parser #(
  parameter int LINE_MAX = ipdc_pkg::LINE_MAX_DEF,
  parameter int KEY_MAX  = ipdc_pkg::KEY_MAX_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] red_level,
  output logic [7:0] green_level,
  output logic [7:0] blue_level,
  output logic       gradient_mode,
  output logic [1:0] outcome
);
  import ipdc_pkg::*;

  logic         hold_valid;
  logic [7:0]   hold_byte;
  logic         out_free;
  logic         go;
  logic         emit;
  ipdc_result_t result;

  assign out_free = !out_valid || !out_stall;
  assign go       = hold_valid && (!emit || out_free);
  assign in_stall = hold_valid && !go;

  ipdc_parser #(
    .LINE_MAX (LINE_MAX),
    .KEY_MAX  (KEY_MAX)
  ) u_parser (
    .clk     (clk),
    .rst     (rst),
    .take    (go),
    .rx_byte (hold_byte),
    .emit    (emit),
    .result  (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      hold_valid <= 1'b1;
    end else if (go) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      hold_byte <= rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (go && emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go && emit) begin
      red_level     <= result.red;
      green_level   <= result.green;
      blue_level    <= result.blue;
      gradient_mode <= result.mode;
      outcome       <= result.outcome;
    end
  end

endmodule
